FILE: hdl/pbfe_pkg.sv
// Package for the playback transport fade envelope: field widths, codes, words, helpers.
package pbfe_pkg;

  // Field widths fixed by the interface
  localparam int GAIN_W  = 20;
  localparam int POS_W   = 40;
  localparam int MS_W    = 16;
  localparam int FR_W    = 16;
  localparam int SR_W    = 18;
  localparam int CNT_W   = 32;
  localparam int TS_W    = 3;
  localparam int ACT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 40;

  // Shared mul/div unit operand widths
  localparam int MD_A_W = 20;
  localparam int MD_B_W = 32;

  // Milliseconds per second, divisor for ms-to-samples
  localparam logic [MD_B_W-1:0] MS_PER_S = 32'd1000;

  // Actions
  localparam logic [ACT_W-1:0] ACT_PLAY      = 4'd0;
  localparam logic [ACT_W-1:0] ACT_STOP      = 4'd1;
  localparam logic [ACT_W-1:0] ACT_STOP_NOW  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_PAUSE     = 4'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME    = 4'd4;
  localparam logic [ACT_W-1:0] ACT_SET_GAIN  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_SEEK      = 4'd6;
  localparam logic [ACT_W-1:0] ACT_STOP_FADE = 4'd7;
  localparam logic [ACT_W-1:0] ACT_RENDER    = 4'd8;

  // Transport states
  localparam logic [TS_W-1:0] TS_STOPPED  = 3'd0;
  localparam logic [TS_W-1:0] TS_FADE_IN  = 3'd1;
  localparam logic [TS_W-1:0] TS_PLAYING  = 3'd2;
  localparam logic [TS_W-1:0] TS_FADE_OUT = 3'd3;
  localparam logic [TS_W-1:0] TS_PAUSED   = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_POINT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_IN       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LOADED = 3'd6;

  // Input word
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [GAIN_W-1:0] gain_value;
    logic [POS_W-1:0]  position;
    logic [MS_W-1:0]   fade_ms;
    logic [FR_W-1:0]   frames_requested;
    logic [FR_W-1:0]   frames_delivered;
    logic              source_at_end;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [TS_W-1:0]   transport;
    logic [GAIN_W-1:0] block_gain_start;
    logic [GAIN_W-1:0] block_gain_end;
    logic [FR_W-1:0]   frames_used;
    logic [POS_W-1:0]  playhead;
    logic              seek_request;
    logic [POS_W-1:0]  seek_frame;
    logic              natural_end;
  } out_word_t;

  // Request to the shared unit: quot = mcand * mplier / divisor
  typedef struct packed {
    logic              start;
    logic [MD_A_W-1:0] mcand;
    logic [MD_B_W-1:0] mplier;
    logic [MD_B_W-1:0] divisor;
  } md_req_t;

  // Magnitude of the ramp span between two gains
  function automatic logic [GAIN_W-1:0] gain_absdiff(input logic [GAIN_W-1:0] a,
                                                     input logic [GAIN_W-1:0] b);
    return (b >= a) ? (b - a) : (a - b);
  endfunction

  // Apply the scaled offset toward b, truncated toward zero
  function automatic logic [GAIN_W-1:0] interp_apply(input logic [GAIN_W-1:0] a,
                                                     input logic [GAIN_W-1:0] b,
                                                     input logic [MD_B_W-1:0] q);
    return (b >= a) ? (a + q[GAIN_W-1:0]) : (a - q[GAIN_W-1:0]);
  endfunction

endpackage

FILE: hdl/pbfe_in_if.sv
// Input event channel: valid/ready with one event word.
interface pbfe_in_if;
  logic                 valid;
  logic                 ready;
  pbfe_pkg::in_word_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pbfe_out_if.sv
// Result channel: valid/ready with one result word.
interface pbfe_out_if;
  logic                 valid;
  logic                 ready;
  pbfe_pkg::out_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/playback_transport_fade_envelope_top.sv
// Top level: transport controller and gain envelope for one audio cue.
// Events without arithmetic pass through accept, decode and report;
// each use of the shared mul/div unit adds a shift-add multiply and a restoring divide.
// A render takes up to three unit passes; play/stop with a fade take one.
// One event at a time: the sequencer and the single mul/div unit set the throughput.
// Reset is synchronous, active low; control, config and transport registers reset, per-event working registers do not.
module playback_transport_fade_envelope_top #(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int SLEW_MS        = 50
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pbfe_in_if.sink                           in_chan,
  pbfe_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [pbfe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbfe_pkg::CFG_DAT_W-1:0]    cfg_data
);

  localparam int GW  = pbfe_pkg::GAIN_W;
  localparam int PW  = pbfe_pkg::POS_W;
  localparam int MW  = pbfe_pkg::MS_W;
  localparam int FW  = pbfe_pkg::FR_W;
  localparam int SW  = pbfe_pkg::SR_W;
  localparam int CW  = pbfe_pkg::CNT_W;
  localparam int TW  = pbfe_pkg::TS_W;
  localparam int MAW = pbfe_pkg::MD_A_W;
  localparam int MBW = pbfe_pkg::MD_B_W;
  localparam logic [GW-1:0]  UNITY_GAIN = GW'(64'd1 << GAIN_FRAC_BITS);
  localparam logic [MAW-1:0] SLEW_OPND  = MAW'(SLEW_MS);
  localparam logic [PW-1:0]  POS_MAX    = {PW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_TOTAL, ST_R_NOW, ST_R_END, ST_R_RAMP, ST_R_SLEW, ST_R_POS,
    ST_REPORT
  } seq_state_t;

  // Configuration registers
  logic [SW-1:0] sample_rate_r, sample_rate_nxt;
  logic [MW-1:0] fade_in_ms_r, fade_in_ms_nxt;
  logic [MW-1:0] fade_out_ms_r, fade_out_ms_nxt;
  logic [PW-1:0] out_point_r, out_point_nxt;
  logic          loop_enable_r, loop_enable_nxt;
  logic [PW-1:0] loop_in_r, loop_in_nxt;
  logic          src_loaded_r, src_loaded_nxt;

  // Transport and envelope state
  seq_state_t    fsm_r, fsm_nxt;
  logic [TW-1:0] ts_r, ts_nxt;
  logic [GW-1:0] gcur_r, gcur_nxt;
  logic [GW-1:0] gtgt_r, gtgt_nxt;
  logic [GW-1:0] ffrom_r, ffrom_nxt;
  logic [GW-1:0] fto_r, fto_nxt;
  logic [CW-1:0] ftotal_r, ftotal_nxt;
  logic [CW-1:0] felap_r, felap_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          fnat_r, fnat_nxt;
  logic          ended_r, ended_nxt;
  logic          seek_req_r, seek_req_nxt;
  logic [PW-1:0] seek_at_r, seek_at_nxt;

  // Per-event working registers
  pbfe_pkg::in_word_t  item_r, item_nxt;
  pbfe_pkg::out_word_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                rendered_r, rendered_nxt;
  logic [FW-1:0]       nread_r, nread_nxt;
  logic [CW-1:0]       ne_r, ne_nxt;
  logic [GW-1:0]       now_r, now_nxt;
  logic [GW-1:0]       end_r, end_nxt;

  // Shared unit
  pbfe_pkg::md_req_t   md_req;
  logic                md_done;
  logic [MBW-1:0]      md_q;

  // Combinational helpers
  logic                do_halt;
  logic                do_fade;
  logic [GW-1:0]       bf_from;
  logic [GW-1:0]       bf_to;
  logic [MW-1:0]       bf_ms;
  logic [TW-1:0]       bf_ts;
  logic [CW:0]         ne_sum;
  logic [MBW-1:0]      ramp;
  logic [GW-1:0]       ramp_gain;
  logic [PW:0]         pos_sum;
  logic [PW-1:0]       pos_new;
  logic                hit;
  logic                active;

  pbfe_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .done  (md_done),
    .quot  (md_q)
  );

  assign in_chan.ready  = (fsm_r == ST_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_r;

  assign active = src_loaded_r && ((ts_r == pbfe_pkg::TS_FADE_IN) ||
                  (ts_r == pbfe_pkg::TS_PLAYING) || (ts_r == pbfe_pkg::TS_FADE_OUT));
  assign ne_sum    = {1'b0, felap_r} + (CW + 1)'(item_r.frames_requested);
  assign ramp      = (md_q == '0) ? MBW'(1) : md_q;
  assign ramp_gain = pbfe_pkg::interp_apply(now_r, gtgt_r, md_q);
  assign pos_sum   = {1'b0, pos_r} + (PW + 1)'(nread_r);
  assign pos_new   = pos_sum[PW] ? POS_MAX : pos_sum[PW-1:0];
  assign hit       = (out_point_r != '0) && (pos_new >= out_point_r);

  always_comb begin
    sample_rate_nxt = sample_rate_r;
    fade_in_ms_nxt  = fade_in_ms_r;
    fade_out_ms_nxt = fade_out_ms_r;
    out_point_nxt   = out_point_r;
    loop_enable_nxt = loop_enable_r;
    loop_in_nxt     = loop_in_r;
    src_loaded_nxt  = src_loaded_r;
    fsm_nxt       = fsm_r;
    ts_nxt        = ts_r;
    gcur_nxt      = gcur_r;
    gtgt_nxt      = gtgt_r;
    ffrom_nxt     = ffrom_r;
    fto_nxt       = fto_r;
    ftotal_nxt    = ftotal_r;
    felap_nxt     = felap_r;
    pos_nxt       = pos_r;
    fnat_nxt      = fnat_r;
    ended_nxt     = ended_r;
    seek_req_nxt  = seek_req_r;
    seek_at_nxt   = seek_at_r;
    item_nxt      = item_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    rendered_nxt  = rendered_r;
    nread_nxt     = nread_r;
    ne_nxt        = ne_r;
    now_nxt       = now_r;
    end_nxt       = end_r;
    md_req        = '0;
    do_halt       = 1'b0;
    do_fade       = 1'b0;
    bf_from       = gcur_r;
    bf_to         = '0;
    bf_ms         = fade_out_ms_r;
    bf_ts         = pbfe_pkg::TS_FADE_OUT;

    // Configuration writes
    if (cfg_we) begin
      case (cfg_index)
        pbfe_pkg::CFG_SAMPLE_RATE:   sample_rate_nxt = cfg_data[SW-1:0];
        pbfe_pkg::CFG_FADE_IN_MS:    fade_in_ms_nxt  = cfg_data[MW-1:0];
        pbfe_pkg::CFG_FADE_OUT_MS:   fade_out_ms_nxt = cfg_data[MW-1:0];
        pbfe_pkg::CFG_OUT_POINT:     out_point_nxt   = cfg_data[PW-1:0];
        pbfe_pkg::CFG_LOOP_ENABLE:   loop_enable_nxt = cfg_data[0];
        pbfe_pkg::CFG_LOOP_IN:       loop_in_nxt     = cfg_data[PW-1:0];
        pbfe_pkg::CFG_SOURCE_LOADED: src_loaded_nxt  = cfg_data[0];
        default: ;
      endcase
    end

    // Result word taken downstream
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (fsm_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          item_nxt = in_chan.data;
          fsm_nxt  = ST_DECODE;
        end
      end

      // Decode the event; most finish here
      ST_DECODE: begin
        seek_req_nxt = 1'b0;
        seek_at_nxt  = '0;
        rendered_nxt = 1'b0;
        fsm_nxt      = ST_REPORT;
        case (item_r.action)
          pbfe_pkg::ACT_PLAY: begin
            if (src_loaded_r && (ts_r != pbfe_pkg::TS_PLAYING) &&
                (ts_r != pbfe_pkg::TS_FADE_IN)) begin
              ended_nxt = 1'b0;
              fnat_nxt  = 1'b0;
              if (fade_in_ms_r != '0) begin
                do_fade = 1'b1;
                bf_from = '0;
                bf_to   = gtgt_r;
                bf_ms   = fade_in_ms_r;
                bf_ts   = pbfe_pkg::TS_FADE_IN;
              end else begin
                gcur_nxt = gtgt_r;
                ts_nxt   = pbfe_pkg::TS_PLAYING;
              end
            end
          end
          pbfe_pkg::ACT_STOP: begin
            if (ts_r == pbfe_pkg::TS_FADE_OUT) begin
              do_halt = 1'b1;
            end else if (ts_r != pbfe_pkg::TS_STOPPED) begin
              fnat_nxt = 1'b0;
              if (fade_out_ms_r != '0) begin
                do_fade = 1'b1;
              end else begin
                do_halt = 1'b1;
              end
            end
          end
          pbfe_pkg::ACT_STOP_NOW: begin
            do_halt = 1'b1;
          end
          pbfe_pkg::ACT_PAUSE: begin
            if ((ts_r == pbfe_pkg::TS_PLAYING) || (ts_r == pbfe_pkg::TS_FADE_IN)) begin
              ts_nxt = pbfe_pkg::TS_PAUSED;
            end
          end
          pbfe_pkg::ACT_RESUME: begin
            if (ts_r == pbfe_pkg::TS_PAUSED) begin
              ts_nxt = pbfe_pkg::TS_PLAYING;
            end
          end
          pbfe_pkg::ACT_SET_GAIN: begin
            gtgt_nxt = item_r.gain_value;
            if (ts_r == pbfe_pkg::TS_STOPPED) begin
              gcur_nxt = item_r.gain_value;
            end
          end
          pbfe_pkg::ACT_SEEK: begin
            pos_nxt      = item_r.position;
            seek_req_nxt = 1'b1;
            seek_at_nxt  = item_r.position;
          end
          pbfe_pkg::ACT_STOP_FADE: begin
            if ((ts_r != pbfe_pkg::TS_STOPPED) && (ts_r != pbfe_pkg::TS_FADE_OUT)) begin
              if (item_r.fade_ms != '0) begin
                do_fade = 1'b1;
                bf_ms   = item_r.fade_ms;
              end else begin
                do_halt = 1'b1;
              end
            end
          end
          pbfe_pkg::ACT_RENDER: begin
            if (active) begin
              rendered_nxt = 1'b1;
              nread_nxt    = (item_r.frames_delivered < item_r.frames_requested) ?
                             item_r.frames_delivered : item_r.frames_requested;
              now_nxt      = gcur_r;
              end_nxt      = gcur_r;
              if ((ts_r != pbfe_pkg::TS_PLAYING) && (ftotal_r != '0)) begin
                // Fade ramp: gain at the block start first
                ne_nxt         = (ne_sum > {1'b0, ftotal_r}) ? ftotal_r : ne_sum[CW-1:0];
                md_req.start   = 1'b1;
                md_req.mcand   = pbfe_pkg::gain_absdiff(ffrom_r, fto_r);
                md_req.mplier  = felap_r;
                md_req.divisor = ftotal_r;
                fsm_nxt        = ST_R_NOW;
              end else if (gtgt_r != gcur_r) begin
                // Slew: ramp length in samples
                md_req.start   = 1'b1;
                md_req.mcand   = SLEW_OPND;
                md_req.mplier  = MBW'(sample_rate_r);
                md_req.divisor = pbfe_pkg::MS_PER_S;
                fsm_nxt        = ST_R_RAMP;
              end else begin
                fsm_nxt = ST_R_POS;
              end
            end
          end
          default: ;
        endcase
      end

      // Fade length in samples arrives
      ST_TOTAL: begin
        if (md_done) begin
          ftotal_nxt = md_q;
          fsm_nxt    = ST_REPORT;
        end
      end

      ST_R_NOW: begin
        if (md_done) begin
          now_nxt        = pbfe_pkg::interp_apply(ffrom_r, fto_r, md_q);
          md_req.start   = 1'b1;
          md_req.mcand   = pbfe_pkg::gain_absdiff(ffrom_r, fto_r);
          md_req.mplier  = ne_r;
          md_req.divisor = ftotal_r;
          fsm_nxt        = ST_R_END;
        end
      end

      // Block end gain; finish the fade when its count runs out
      ST_R_END: begin
        if (md_done) begin
          end_nxt   = pbfe_pkg::interp_apply(ffrom_r, fto_r, md_q);
          felap_nxt = ne_r;
          if (ne_r >= ftotal_r) begin
            gcur_nxt = fto_r;
            if (ts_r == pbfe_pkg::TS_FADE_IN) begin
              ts_nxt = pbfe_pkg::TS_PLAYING;
            end else begin
              ts_nxt = pbfe_pkg::TS_STOPPED;
              if (fnat_r) begin
                fnat_nxt  = 1'b0;
                ended_nxt = 1'b1;
              end
            end
          end else begin
            gcur_nxt = pbfe_pkg::interp_apply(ffrom_r, fto_r, md_q);
          end
          fsm_nxt = ST_R_POS;
        end
      end

      ST_R_RAMP: begin
        if (md_done) begin
          if (MBW'(item_r.frames_requested) >= ramp) begin
            end_nxt  = gtgt_r;
            gcur_nxt = gtgt_r;
            fsm_nxt  = ST_R_POS;
          end else begin
            md_req.start   = 1'b1;
            md_req.mcand   = pbfe_pkg::gain_absdiff(gcur_r, gtgt_r);
            md_req.mplier  = MBW'(item_r.frames_requested);
            md_req.divisor = ramp;
            fsm_nxt        = ST_R_SLEW;
          end
        end
      end

      ST_R_SLEW: begin
        if (md_done) begin
          end_nxt  = ramp_gain;
          gcur_nxt = ramp_gain;
          fsm_nxt  = ST_R_POS;
        end
      end

      // Advance the playhead and handle the end of the block
      ST_R_POS: begin
        pos_nxt = pos_new;
        fsm_nxt = ST_REPORT;
        if (item_r.source_at_end || (nread_r < item_r.frames_requested) || hit) begin
          if (loop_enable_r) begin
            pos_nxt      = loop_in_r;
            seek_req_nxt = 1'b1;
            seek_at_nxt  = loop_in_r;
          end else if ((ts_r == pbfe_pkg::TS_PLAYING) || (ts_r == pbfe_pkg::TS_FADE_IN)) begin
            if (fade_out_ms_r != '0) begin
              fnat_nxt = 1'b1;
              do_fade  = 1'b1;
            end else begin
              fnat_nxt  = 1'b0;
              ended_nxt = 1'b1;
              ts_nxt    = pbfe_pkg::TS_STOPPED;
            end
          end
        end
      end

      // Load the result word once the output register is free
      ST_REPORT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt.transport        = ts_r;
          out_nxt.block_gain_start = rendered_r ? now_r : gcur_r;
          out_nxt.block_gain_end   = rendered_r ? end_r : gcur_r;
          out_nxt.frames_used      = rendered_r ? nread_r : '0;
          out_nxt.playhead         = pos_r;
          out_nxt.seek_request     = seek_req_r;
          out_nxt.seek_frame       = seek_req_r ? seek_at_r : '0;
          out_nxt.natural_end      = ended_r;
          out_valid_nxt            = 1'b1;
          ended_nxt                = 1'b0;
          fsm_nxt                  = ST_IDLE;
        end
      end

      default: begin
        fsm_nxt = ST_IDLE;
      end
    endcase

    // Immediate stop
    if (do_halt) begin
      fnat_nxt     = 1'b0;
      ended_nxt    = 1'b0;
      ts_nxt       = pbfe_pkg::TS_STOPPED;
      gcur_nxt     = gtgt_r;
      ftotal_nxt   = '0;
      felap_nxt    = '0;
      pos_nxt      = '0;
      seek_req_nxt = 1'b1;
      seek_at_nxt  = '0;
    end

    // Start a fade; its sample count comes from the shared unit
    if (do_fade) begin
      ffrom_nxt      = bf_from;
      fto_nxt        = bf_to;
      felap_nxt      = '0;
      gcur_nxt       = bf_from;
      ts_nxt         = bf_ts;
      md_req.start   = 1'b1;
      md_req.mcand   = MAW'(bf_ms);
      md_req.mplier  = MBW'(sample_rate_r);
      md_req.divisor = pbfe_pkg::MS_PER_S;
      fsm_nxt        = ST_TOTAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= SW'(48000);
      fade_in_ms_r  <= '0;
      fade_out_ms_r <= '0;
      out_point_r   <= '0;
      loop_enable_r <= 1'b0;
      loop_in_r     <= '0;
      src_loaded_r  <= 1'b0;
      fsm_r         <= ST_IDLE;
      ts_r          <= pbfe_pkg::TS_STOPPED;
      gcur_r        <= UNITY_GAIN;
      gtgt_r        <= UNITY_GAIN;
      ffrom_r       <= '0;
      fto_r         <= '0;
      ftotal_r      <= '0;
      felap_r       <= '0;
      pos_r         <= '0;
      fnat_r        <= 1'b0;
      ended_r       <= 1'b0;
      seek_req_r    <= 1'b0;
      seek_at_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      sample_rate_r <= sample_rate_nxt;
      fade_in_ms_r  <= fade_in_ms_nxt;
      fade_out_ms_r <= fade_out_ms_nxt;
      out_point_r   <= out_point_nxt;
      loop_enable_r <= loop_enable_nxt;
      loop_in_r     <= loop_in_nxt;
      src_loaded_r  <= src_loaded_nxt;
      fsm_r         <= fsm_nxt;
      ts_r          <= ts_nxt;
      gcur_r        <= gcur_nxt;
      gtgt_r        <= gtgt_nxt;
      ffrom_r       <= ffrom_nxt;
      fto_r         <= fto_nxt;
      ftotal_r      <= ftotal_nxt;
      felap_r       <= felap_nxt;
      pos_r         <= pos_nxt;
      fnat_r        <= fnat_nxt;
      ended_r       <= ended_nxt;
      seek_req_r    <= seek_req_nxt;
      seek_at_r     <= seek_at_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    out_r      <= out_nxt;
    rendered_r <= rendered_nxt;
    nread_r    <= nread_nxt;
    ne_r       <= ne_nxt;
    now_r      <= now_nxt;
    end_r      <= end_nxt;
  end

endmodule

FILE: hdl/pbfe_muldiv.sv
// Shared sequential unit: floor(mcand * mplier / divisor), shift-add then restoring divide.
module pbfe_muldiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbfe_pkg::md_req_t             req,
  output logic                          done,
  output logic [pbfe_pkg::MD_B_W-1:0]   quot
);

  localparam int A_W       = pbfe_pkg::MD_A_W;
  localparam int B_W       = pbfe_pkg::MD_B_W;
  localparam int P_W       = A_W + B_W;
  localparam int MUL_STEPS = A_W;
  localparam int DIV_STEPS = B_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_t;

  md_state_t         st_r, st_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [A_W-1:0]    a_r, a_nxt;
  logic [B_W-1:0]    b_r, b_nxt;
  logic [B_W-1:0]    d_r, d_nxt;
  logic [P_W-1:0]    acc_r, acc_nxt;
  logic [B_W-1:0]    rem_r, rem_nxt;
  logic              done_r, done_nxt;

  logic [P_W-1:0]    mul_sum;
  logic [B_W:0]      div_t;
  logic [B_W:0]      div_diff;
  logic              div_ge;

  // One partial product per cycle, multiplicand MSB first
  assign mul_sum = {acc_r[P_W-2:0], 1'b0} + (a_r[A_W-1] ? P_W'(b_r) : '0);

  // One quotient bit per cycle; the high part must start below the divisor, which the unit does not check
  assign div_t    = {rem_r, acc_r[B_W-1]};
  assign div_diff = div_t - {1'b0, d_r};
  assign div_ge   = (div_t >= {1'b0, d_r});

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          a_nxt   = req.mcand;
          b_nxt   = req.mplier;
          d_nxt   = req.divisor;
          acc_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = MD_MUL;
        end
      end
      MD_MUL: begin
        acc_nxt = mul_sum;
        a_nxt   = {a_r[A_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(MUL_STEPS - 1)) begin
          rem_nxt = B_W'(mul_sum[P_W-1:B_W]);
          cnt_nxt = '0;
          st_nxt  = MD_DIV;
        end
      end
      MD_DIV: begin
        rem_nxt = div_ge ? div_diff[B_W-1:0] : div_t[B_W-1:0];
        acc_nxt = {acc_r[P_W-1:B_W], acc_r[B_W-2:0], div_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          done_nxt = 1'b1;
          st_nxt   = MD_IDLE;
        end
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = acc_r[B_W-1:0];

endmodule
